// File: rtl/rotor_speed_setpoint_selector_defines.svh
// Assertion macros used by the checker of the rotor speed setpoint selector.
`ifndef ROTOR_SPEED_SETPOINT_SELECTOR_DEFINES_SVH
`define ROTOR_SPEED_SETPOINT_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/rss_pkg.sv
`default_nettype none
package rss_pkg;

	// Event kinds
	typedef enum logic [2:0] {
		CMD_SOURCE     = 3'd0,
		CMD_FOOTSWITCH = 3'd1,
		CMD_PEDAL      = 3'd2,
		CMD_BUTTON     = 3'd3,
		CMD_CC         = 3'd4
	} rss_cmd_t;

	// Input sources
	typedef enum logic [1:0] {
		SRC_FOOT  = 2'd0,
		SRC_PEDAL = 2'd1,
		SRC_KEYS  = 2'd2,
		SRC_SYNC  = 2'd3
	} rss_src_t;

	// Keyboard buttons
	localparam logic [1:0] BTN_CHORALE = 2'd0;
	localparam logic [1:0] BTN_STOP    = 2'd1;
	localparam logic [1:0] BTN_TREMOLO = 2'd2;

	// Configuration register indexes
	localparam logic CFG_RATE_CC   = 1'b0;
	localparam logic CFG_SUBDIV_CC = 1'b1;

	localparam int SPEED_W = 13;
	localparam int CC_W    = 7;
	localparam int CC_VALUES = 1 << CC_W;

	localparam int SPEED_MAX             = 8191;
	localparam int RPM_HORN_CHORALE      = 40;
	localparam int RPM_HORN_TREMOLO      = 420;
	localparam int RPM_DRUM_CHORALE      = 35;
	localparam int RPM_DRUM_TREMOLO      = 350;
	localparam int RPM_FOOT_HORN_CHORALE = 50;
	localparam int RPM_FOOT_DRUM_CHORALE = 44;
	localparam int RPM_RATE_MAX          = 400;
	localparam int CC_TOP                = 127;
	localparam int CC_DEAD_ZONE          = 10;
	localparam int CC_SPAN               = CC_TOP - CC_DEAD_ZONE;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [1:0]      new_source;
		logic            switch_a;
		logic            switch_b;
		logic [1:0]      button_id;
		logic [CC_W-1:0] cc_number;
		logic [CC_W-1:0] cc_value;
	} rss_event_t;

	typedef struct packed {
		logic               beat_sync_mode;
		logic [SPEED_W-1:0] horn_speed;
		logic [SPEED_W-1:0] drum_speed;
		logic               subdiv_commit;
		logic [CC_W-1:0]    subdiv_value;
	} rss_result_t;

	// Clamp a speed to the setpoint range
	function automatic logic [SPEED_W-1:0] sat_speed(input int v);
		logic [SPEED_W-1:0] r;
		if (v > SPEED_MAX) begin
			r = SPEED_W'(SPEED_MAX);
		end else begin
			r = SPEED_W'(v);
		end
		return r;
	endfunction

	// Whole rpm to fixed point
	function automatic logic [SPEED_W-1:0] rpm_fixed(input int rpm, input int frac);
		return sat_speed(rpm << frac);
	endfunction

	// Horn speed for a rate CC value, deadband and cap applied
	function automatic logic [SPEED_W-1:0] rate_horn(input int v, input int frac);
		int h;
		int cap;
		h = 0;
		cap = RPM_RATE_MAX << frac;
		if (v > CC_DEAD_ZONE) begin
			h = ((v - CC_DEAD_ZONE) * RPM_RATE_MAX << frac) / CC_SPAN;
			if (h > cap) begin
				h = cap;
			end
		end
		return sat_speed(h);
	endfunction

	// Drum speed follows the horn at five sixths
	function automatic logic [SPEED_W-1:0] rate_drum(input int v, input int frac);
		int h;
		h = int'(rate_horn(v, frac));
		return sat_speed((h * 5) / 6);
	endfunction

endpackage
`default_nettype wire

// File: rtl/rotor_speed_setpoint_selector.sv
// Rotor speed setpoint selector. Takes one operator event per clock cycle
// unless stalled and returns one result per event showing the source and
// speed setpoints after it. An event is registered on transfer, decoded in
// the following cycle against the active source and the setpoints, and the
// result lands in the output register, with a single decode stage between
// the input and output registers. A stalled output backs the input up only
// once both registers are full. The rate CC maps through a constant table
// indexed by the CC value. Configuration writes are always ready and take
// effect on the next event.
`default_nettype none
module rotor_speed_setpoint_selector
	import rss_pkg::*;
#(
	parameter int SPEED_FRAC_BITS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rss_event_t        in_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rss_result_t            out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [CC_W-1:0]   cfg_data
);

	localparam logic [SPEED_W-1:0] HORN_TREMOLO = rpm_fixed(RPM_HORN_TREMOLO, SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] DRUM_TREMOLO = rpm_fixed(RPM_DRUM_TREMOLO, SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] HORN_CHORALE = rpm_fixed(RPM_HORN_CHORALE, SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] DRUM_CHORALE = rpm_fixed(RPM_DRUM_CHORALE, SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] HORN_FOOT_CH =
		rpm_fixed(RPM_FOOT_HORN_CHORALE, SPEED_FRAC_BITS);
	localparam logic [SPEED_W-1:0] DRUM_FOOT_CH =
		rpm_fixed(RPM_FOOT_DRUM_CHORALE, SPEED_FRAC_BITS);

	logic [CC_W-1:0]    rate_cc_q;
	logic [CC_W-1:0]    subdiv_cc_q;
	rss_src_t           src_q;
	logic [SPEED_W-1:0] horn_q;
	logic [SPEED_W-1:0] drum_q;

	logic               valid_s1;
	rss_event_t         ev_s1;

	logic               out_valid_q;
	rss_result_t        out_data_q;

	logic               advance;
	rss_src_t           src_d;
	logic [SPEED_W-1:0] horn_d;
	logic [SPEED_W-1:0] drum_d;
	logic               commit_d;
	logic [CC_W-1:0]    subval_d;

	logic [SPEED_W-1:0] horn_lut [CC_VALUES];
	logic [SPEED_W-1:0] drum_lut [CC_VALUES];

	// Rate CC to speed tables, folded at elaboration
	for (genvar gi = 0; gi < CC_VALUES; gi++) begin : g_rate
		assign horn_lut[gi] = rate_horn(gi, SPEED_FRAC_BITS);
		assign drum_lut[gi] = rate_drum(gi, SPEED_FRAC_BITS);
	end

	// Handshake: output register drains, decode stage refills
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_cc_q   <= CC_W'(1);
			subdiv_cc_q <= CC_W'(3);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RATE_CC:   rate_cc_q   <= cfg_data;
				CFG_SUBDIV_CC: subdiv_cc_q <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ev_s1 <= in_data;
		end
	end

	// Decode the event against the active source
	always_comb begin
		src_d    = src_q;
		horn_d   = horn_q;
		drum_d   = drum_q;
		commit_d = 1'b0;
		subval_d = '0;
		if (ev_s1.cmd == CMD_SOURCE) begin
			src_d = rss_src_t'(ev_s1.new_source);
		end else begin
			unique case (src_q)
				SRC_FOOT: begin
					if (ev_s1.cmd == CMD_FOOTSWITCH) begin
						priority if (ev_s1.switch_a && ev_s1.switch_b) begin
							horn_d = HORN_TREMOLO;
							drum_d = DRUM_TREMOLO;
						end else if (ev_s1.switch_a) begin
							horn_d = HORN_FOOT_CH;
							drum_d = DRUM_FOOT_CH;
						end else begin
							horn_d = '0;
							drum_d = '0;
						end
					end
				end
				SRC_KEYS: begin
					if (ev_s1.cmd == CMD_BUTTON) begin
						unique case (ev_s1.button_id)
							BTN_CHORALE: begin
								horn_d = HORN_CHORALE;
								drum_d = DRUM_CHORALE;
							end
							BTN_STOP: begin
								horn_d = '0;
								drum_d = '0;
							end
							BTN_TREMOLO: begin
								horn_d = HORN_TREMOLO;
								drum_d = DRUM_TREMOLO;
							end
							default: ;
						endcase
					end else if (ev_s1.cmd == CMD_CC && ev_s1.cc_number == rate_cc_q) begin
						horn_d = horn_lut[ev_s1.cc_value];
						drum_d = drum_lut[ev_s1.cc_value];
					end
				end
				SRC_SYNC: begin
					if (ev_s1.cmd == CMD_CC && ev_s1.cc_number == subdiv_cc_q) begin
						commit_d = 1'b1;
						subval_d = ev_s1.cc_value;
					end
				end
				SRC_PEDAL: ;
				default: ;
			endcase
		end
	end

	// Commit state and result on transfer out of the decode stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q       <= SRC_FOOT;
			horn_q      <= '0;
			drum_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				src_q  <= src_d;
				horn_q <= horn_d;
				drum_q <= drum_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_data_q.beat_sync_mode <= (src_d == SRC_SYNC);
			out_data_q.horn_speed     <= horn_d;
			out_data_q.drum_speed     <= drum_d;
			out_data_q.subdiv_commit  <= commit_d;
			out_data_q.subdiv_value   <= subval_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/rss_checker.sv
`default_nettype none
`include "rotor_speed_setpoint_selector_defines.svh"
module rss_checker
	import rss_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire rss_result_t out_data
);

	// Hold a stalled result
	`RSS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// Back up the input only behind a full, stalled output
	`RSS_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

	// Commit a subdivision only in beat-sync mode, and zero its value otherwise
	`RSS_ASSERT_IMP(a_commit_mode, clk, arst_n, out_valid && out_data.subdiv_commit, out_data.beat_sync_mode)
	`RSS_ASSERT_IMP(a_subdiv_zero, clk, arst_n, out_valid && !out_data.subdiv_commit, out_data.subdiv_value == '0)

	// Keep the drum no faster than the horn
	`RSS_ASSERT_IMP(a_drum_le_horn, clk, arst_n, out_valid, out_data.drum_speed <= out_data.horn_speed)

endmodule

bind rotor_speed_setpoint_selector rss_checker u_rss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

// File: tb/sv/setpoint_monitor.sv
`timescale 1ns / 100ps
module setpoint_monitor
	import rss_pkg::*;
#(
	parameter int SPEED_FRAC = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_stall,
	input  wire rss_event_t      in_data,
	input  wire logic            out_valid,
	input  wire logic            out_stall,
	input  wire rss_result_t     out_data,
	input  wire logic            cfg_valid,
	input  wire logic            cfg_ready,
	input  wire logic            cfg_index,
	input  wire logic [CC_W-1:0] cfg_data,
	output int                   fail_count,
	output int                   pending
);

	// Shadow of the selector state and its controller numbers
	rss_src_t           active_src = SRC_FOOT;
	logic [SPEED_W-1:0] horn_sp    = '0;
	logic [SPEED_W-1:0] drum_sp    = '0;
	logic [CC_W-1:0]    rate_cc    = CC_W'(1);
	logic [CC_W-1:0]    subdiv_cc  = CC_W'(3);

	rss_result_t pending_setpoints[$];
	int          errors = 0;

	assign fail_count = errors;

	initial pending = 0;

	// Clamp a fixed-point speed to the setpoint width
	function automatic logic [SPEED_W-1:0] clamp_speed(input int v);
		return (v > SPEED_MAX) ? SPEED_W'(SPEED_MAX) : SPEED_W'(v);
	endfunction

	// Load both setpoints from whole-rpm presets
	function automatic void load_preset(input int horn_rpm, input int drum_rpm);
		horn_sp = clamp_speed(horn_rpm << SPEED_FRAC);
		drum_sp = clamp_speed(drum_rpm << SPEED_FRAC);
	endfunction

	// Advance the shadow state by one event and return the setpoints after it
	function automatic rss_result_t next_setpoints(input rss_event_t ev);
		rss_result_t r;
		int          h;
		r = '0;
		if (ev.cmd == CMD_SOURCE) begin
			active_src = rss_src_t'(ev.new_source);
		end else begin
			case (active_src)
				SRC_FOOT: begin
					if (ev.cmd == CMD_FOOTSWITCH) begin
						if (ev.switch_a && ev.switch_b) begin
							load_preset(RPM_HORN_TREMOLO, RPM_DRUM_TREMOLO);
						end else if (ev.switch_a) begin
							load_preset(RPM_FOOT_HORN_CHORALE, RPM_FOOT_DRUM_CHORALE);
						end else begin
							load_preset(0, 0);
						end
					end
				end
				SRC_KEYS: begin
					if (ev.cmd == CMD_BUTTON) begin
						case (ev.button_id)
							BTN_CHORALE: load_preset(RPM_HORN_CHORALE, RPM_DRUM_CHORALE);
							BTN_STOP:    load_preset(0, 0);
							BTN_TREMOLO: load_preset(RPM_HORN_TREMOLO, RPM_DRUM_TREMOLO);
							default: ;
						endcase
					end else if (ev.cmd == CMD_CC && ev.cc_number == rate_cc) begin
						// deadband, linear map to the rate ceiling, truncate
						h = 0;
						if (int'(ev.cc_value) > CC_DEAD_ZONE) begin
							h = ((int'(ev.cc_value) - CC_DEAD_ZONE) * RPM_RATE_MAX
								* (1 << SPEED_FRAC)) / (CC_TOP - CC_DEAD_ZONE);
							if (h > (RPM_RATE_MAX << SPEED_FRAC)) begin
								h = RPM_RATE_MAX << SPEED_FRAC;
							end
						end
						horn_sp = clamp_speed(h);
						drum_sp = clamp_speed((int'(horn_sp) * 5) / 6);
					end
				end
				SRC_SYNC: begin
					if (ev.cmd == CMD_CC && ev.cc_number == subdiv_cc) begin
						r.subdiv_commit = 1'b1;
						r.subdiv_value  = ev.cc_value;
					end
				end
				default: ;
			endcase
		end
		r.beat_sync_mode = (active_src == SRC_SYNC);
		r.horn_speed     = horn_sp;
		r.drum_speed     = drum_sp;
		return r;
	endfunction

	// Track config writes, predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		rss_result_t exp_r;
		logic        bad;
		if (!arst_n) begin
			active_src = SRC_FOOT;
			horn_sp    = '0;
			drum_sp    = '0;
			rate_cc    = CC_W'(1);
			subdiv_cc  = CC_W'(3);
			pending_setpoints.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_setpoints.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result with nothing expected: sync=%0d horn=%0d drum=%0d commit=%0d sub=%0d",
							$realtime, out_data.beat_sync_mode, out_data.horn_speed,
							out_data.drum_speed, out_data.subdiv_commit, out_data.subdiv_value);
					end
				end else begin
					exp_r = pending_setpoints.pop_front();
					bad = (out_data.beat_sync_mode !== exp_r.beat_sync_mode)
						|| (out_data.horn_speed !== exp_r.horn_speed)
						|| (out_data.drum_speed !== exp_r.drum_speed)
						|| (out_data.subdiv_commit !== exp_r.subdiv_commit)
						|| (out_data.subdiv_value !== exp_r.subdiv_value);
					if (bad) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch exp sync=%0d horn=%0d drum=%0d commit=%0d sub=%0d | got sync=%0d horn=%0d drum=%0d commit=%0d sub=%0d",
								$realtime, exp_r.beat_sync_mode, exp_r.horn_speed,
								exp_r.drum_speed, exp_r.subdiv_commit, exp_r.subdiv_value,
								out_data.beat_sync_mode, out_data.horn_speed,
								out_data.drum_speed, out_data.subdiv_commit,
								out_data.subdiv_value);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				pending_setpoints.push_back(next_setpoints(in_data));
			end
			// config writes land after the event of the same edge
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RATE_CC) begin
					rate_cc = cfg_data;
				end else begin
					subdiv_cc = cfg_data;
				end
			end
			pending <= pending_setpoints.size();
		end
	end

endmodule

// File: tb/sv/rotor_speed_setpoint_selector_tb.sv
`timescale 1ns / 100ps
module rotor_speed_setpoint_selector_tb;
	import rss_pkg::*;

	localparam int         SPEED_FRAC   = 4;
	localparam int         EVENT_W      = $bits(rss_event_t);
	localparam logic [2:0] CMD_RESERVED = 3'd7;
	localparam logic [1:0] BTN_UNUSED   = 2'd3;
	localparam int         PHASES       = 6;
	localparam int         PHASE_ITEMS  = 170;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            in_valid  = 1'b0;
	logic            in_stall;
	rss_event_t      in_data   = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	rss_result_t     out_data;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic            cfg_index = CFG_RATE_CC;
	logic [CC_W-1:0] cfg_data  = '0;
	int              fail_count;
	int              pending;

	// Stimulus-side view: current controller numbers and the last selected source
	logic [CC_W-1:0] rate_cc    = CC_W'(1);
	logic [CC_W-1:0] subdiv_cc  = CC_W'(3);
	rss_src_t        cur_src    = SRC_FOOT;
	int              quiet_left = 0;

	always #5 clk = ~clk;

	rotor_speed_setpoint_selector #(
		.SPEED_FRAC_BITS(SPEED_FRAC)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	setpoint_monitor #(
		.SPEED_FRAC(SPEED_FRAC)
	) u_monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic rss_event_t mk_event(input logic [2:0] cmd, input logic [1:0] src,
		input logic sw_a, input logic sw_b, input logic [1:0] btn,
		input logic [CC_W-1:0] ccn, input logic [CC_W-1:0] ccv);
		rss_event_t ev;
		ev.cmd        = cmd;
		ev.new_source = src;
		ev.switch_a   = sw_a;
		ev.switch_b   = sw_b;
		ev.button_id  = btn;
		ev.cc_number  = ccn;
		ev.cc_value   = ccv;
		return ev;
	endfunction

	// Random event shaped for the source in force; a share stays pure noise
	function automatic rss_event_t random_event();
		rss_event_t ev;
		int         r;
		int         pick;
		ev   = EVENT_W'($urandom);
		r    = $urandom_range(99);
		pick = $urandom_range(99);
		if (r < 10) begin
			ev.cmd = CMD_SOURCE;
		end else if (r >= 20) begin
			case (cur_src)
				SRC_FOOT: ev.cmd = CMD_FOOTSWITCH;
				SRC_KEYS: ev.cmd = (r < 55) ? CMD_BUTTON : CMD_CC;
				default:  ev.cmd = CMD_CC;
			endcase
		end
		if (pick < 45) begin
			ev.cc_number = rate_cc;
		end else if (pick < 85) begin
			ev.cc_number = subdiv_cc;
		end
		return ev;
	endfunction

	// Hold the event until transfer; called and returning at a falling edge
	task automatic send_event(input rss_event_t ev);
		int gap;
		gap = (quiet_left > 0) ? 0 : pick_gap();
		if (quiet_left > 0) begin
			quiet_left--;
		end else if ($urandom_range(99) < 2) begin
			quiet_left = $urandom_range(80, 30);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= ev;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		if (ev.cmd == CMD_SOURCE) begin
			cur_src = rss_src_t'(ev.new_source);
		end
	endtask

	// Stop sending and wait until every expected result has come
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	// Write both controller numbers back to back, valid held across the pair
	task automatic set_cc_numbers(input logic [CC_W-1:0] rate_n, input logic [CC_W-1:0] sub_n);
		cfg_index <= CFG_RATE_CC;
		cfg_data  <= rate_n;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_index <= CFG_SUBDIV_CC;
		cfg_data  <= sub_n;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		rate_cc   = rate_n;
		subdiv_cc = sub_n;
	endtask

	// Receiver stall pattern
	initial begin
		int n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(99) < 4) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(80, 30)) @(negedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(negedge clk);
				end
				out_stall <= 1'b0;
				repeat (pick_gap() + 1) @(negedge clk);
			end
		end
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [CC_W-1:0] r_n;
		logic [CC_W-1:0] s_n;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Footswitch presets, then an event that footswitch mode ignores
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b1, 1'b1, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b1, 1'b0, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b0, 1'b1, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b1, 1'b1, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_BUTTON, SRC_SYNC, 1'b1, 1'b1, BTN_TREMOLO, 7'd127, 7'd127));

		// Expression pedal source ignores everything but a source change
		send_event(mk_event(CMD_SOURCE, SRC_PEDAL, 1'b0, 1'b0, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b1, 1'b1, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd1, 7'd127));

		// Keyboard buttons, unused button, rate CC around the deadband and at the top, other events ignored
		send_event(mk_event(CMD_SOURCE, SRC_KEYS, 1'b0, 1'b0, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_BUTTON, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_BUTTON, SRC_FOOT, 1'b0, 1'b0, BTN_TREMOLO, 7'd0, 7'd0));
		send_event(mk_event(CMD_BUTTON, SRC_FOOT, 1'b0, 1'b0, BTN_UNUSED, 7'd0, 7'd0));
		send_event(mk_event(CMD_BUTTON, SRC_FOOT, 1'b0, 1'b0, BTN_STOP, 7'd0, 7'd0));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd1, 7'd127));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd1, 7'd11));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd0, 7'd127));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd1, 7'd10));
		send_event(mk_event(CMD_RESERVED, SRC_SYNC, 1'b1, 1'b1, BTN_UNUSED, 7'd1, 7'd127));
		send_event(mk_event(CMD_PEDAL, SRC_FOOT, 1'b1, 1'b1, BTN_TREMOLO, 7'd1, 7'd127));
		send_event(mk_event(CMD_FOOTSWITCH, SRC_FOOT, 1'b1, 1'b1, BTN_CHORALE, 7'd0, 7'd0));

		// Beat sync: subdivision commits at both ends, other CCs ignored
		send_event(mk_event(CMD_SOURCE, SRC_SYNC, 1'b0, 1'b0, BTN_CHORALE, 7'd0, 7'd0));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd3, 7'd127));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd3, 7'd0));
		send_event(mk_event(CMD_CC, SRC_FOOT, 1'b0, 1'b0, BTN_CHORALE, 7'd127, 7'd127));
		send_event(mk_event(CMD_SOURCE, SRC_FOOT, 1'b1, 1'b1, BTN_UNUSED, 7'd127, 7'd127));
		drain();

		// Random phases, controller numbers changed only while idle
		for (int p = 0; p < PHASES; p++) begin
			r_n = CC_W'($urandom);
			s_n = CC_W'($urandom);
			case (p)
				0: set_cc_numbers(7'd0, 7'd127);
				1: set_cc_numbers(7'd127, 7'd0);
				2: set_cc_numbers(r_n, r_n);
				default: set_cc_numbers(r_n, s_n);
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				send_event(random_event());
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/rss_pkg.sv
rtl/rotor_speed_setpoint_selector.sv
rtl/rss_checker.sv
tb/sv/setpoint_monitor.sv
tb/sv/rotor_speed_setpoint_selector_tb.sv
